/* rtl/core/wrtt_pkg.sv */
// Shared constants and types for the windowed RTT tracker.
package wrtt_pkg;

    // Default store depth
    localparam int MAX_SAMPLES_DEF = 16;

    // Field widths
    localparam int RTT_W     = 16;
    localparam int TIME_W    = 32;
    localparam int TIMEOUT_W = 16;
    localparam int WEIGHT_W  = 4;
    localparam int RES_W     = 17;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Width of prev*(10-w) + mean*w, at most 65535*10
    localparam int BLEND_W = 20;

    // Divide by ten as multiply by ceil(2^23/10), exact below 2^22
    localparam int                 RECIP_SHIFT = 23;
    localparam logic [BLEND_W-1:0] RECIP_TEN   = 20'd838861;

    // Register reset values and the full weight of ten tenths
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd1500;
    localparam logic [WEIGHT_W-1:0]  WEIGHT_RST  = 4'd3;
    localparam logic [WEIGHT_W-1:0]  WEIGHT_FULL = 4'd10;

    // Configuration register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_TIMEOUT = 1'b0,
        REG_WEIGHT  = 1'b1
    } reg_idx_t;

endpackage

/* rtl/core/wrtt_div.sv */
// Restoring divider, one quotient bit per cycle, for the window mean.
module wrtt_div #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quot,
    output logic             done
);

    localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  q_reg;
    logic [DEN_W-1:0]  rem_reg;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {rem_reg, q_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den};

    // Control: run NUM_W steps, flag the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: keep the remainder, shift quotient bits into q
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den})
            begin
                rem_reg <= diff[DEN_W-1:0];
                q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DEN_W-1:0];
                q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

/* rtl/core/windowed_rtt_tracker.sv */
// Windowed RTT tracker: timestamped sample store, age purge, max, mean and smoothing.
//
//   channel   direction  handshake             payload
//   in        sink       in_valid / in_stall   req_type, rtt_ms, now_ms
//   out       source     out_valid / out_stall rtt_peak, rtt_smooth, rtt_valid
//   cfg       APB slave  psel/penable/pready   paddr, pwdata, prdata
//
// One item at a time: a report first appends its sample, then each of the
// n stored samples takes a memory read, then an age check and repack, one
// more read ends the scan, and the mean goes through the divider;
// smoothing adds a blend step and one reciprocal multiply for the divide by
// ten. A tick skips the append. No clearing pass after reset; a tick that
// leaves the window empty gives -1.
// The finished transfer sits in the output register, and the next item is
// taken while it waits; a new result waits until the old one is taken.
module windowed_rtt_tracker
    import wrtt_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // input channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       req_type,
    input  logic [RTT_W-1:0]           rtt_ms,
    input  logic [TIME_W-1:0]          now_ms,
    // output channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [RES_W-1:0]    rtt_peak,
    output logic signed [RES_W-1:0]    rtt_smooth,
    output logic                       rtt_valid,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready
);

    localparam int IDX_W     = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W     = RTT_W + CNT_W;
    localparam int DIV_NUM_W = SUM_W;
    localparam int DIV_DEN_W = CNT_W;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);
    localparam logic [IDX_W:0]   MAX_POS = (IDX_W + 1)'(MAX_SAMPLES);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_APPEND = 8'b0000_0010,
        S_READ   = 8'b0000_0100,
        S_CHECK  = 8'b0000_1000,
        S_DIVM   = 8'b0001_0000,
        S_MIX    = 8'b0010_0000,
        S_DIVA   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    // Ring position: base + offset, wrapped once at the store depth
    function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= MAX_POS)
        begin
            s = s - MAX_POS;
        end
        return s[IDX_W-1:0];
    endfunction

    state_t                    state_reg, state_next;

    logic [TIMEOUT_W-1:0]      timeout_reg;
    logic [WEIGHT_W-1:0]       weight_reg;

    logic                      req_reg;
    logic [RTT_W-1:0]          rtt_in_reg;
    logic [TIME_W-1:0]         now_reg;

    logic [IDX_W-1:0]          oldest_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          k_reg;
    logic [CNT_W-1:0]          kept_reg;
    logic [RTT_W-1:0]          max_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic [RTT_W-1:0]          mean_reg;
    logic [RTT_W-1:0]          avg_reg;
    logic                      avg_valid_reg;
    logic [BLEND_W-1:0]        blend_reg;

    logic                      out_valid_reg;
    logic signed [RES_W-1:0]   out_max_reg;
    logic signed [RES_W-1:0]   out_avg_reg;
    logic                      out_flag_reg;

    // Sample store
    logic [RTT_W-1:0]          mem_rtt  [MAX_SAMPLES];
    logic [TIME_W-1:0]         mem_time [MAX_SAMPLES];
    logic [RTT_W-1:0]          rd_rtt_reg;
    logic [TIME_W-1:0]         rd_time_reg;

    logic                      in_xfer;
    logic                      out_free;
    logic                      cfg_write;
    logic                      store_full;
    logic                      scan_end;
    logic [TIME_W-1:0]         age;
    logic                      keep;
    logic [IDX_W-1:0]          rd_addr;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic [RTT_W-1:0]          wr_rtt;
    logic [TIME_W-1:0]         wr_time;
    logic [WEIGHT_W-1:0]       w_eff;
    logic [BLEND_W-1:0]        blend;
    logic [2*BLEND_W-1:0]      blend_prod;

    logic                      div_start;
    logic [DIV_NUM_W-1:0]      div_num;
    logic [DIV_DEN_W-1:0]      div_den;
    logic [DIV_NUM_W-1:0]      div_quot;
    logic                      div_done;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration registers
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RST;
            weight_reg  <= WEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(paddr[2]))
                REG_TIMEOUT: timeout_reg <= pwdata[TIMEOUT_W-1:0];
                REG_WEIGHT:  weight_reg  <= pwdata[WEIGHT_W-1:0];
                default:     timeout_reg <= timeout_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[2]))
            REG_TIMEOUT: prdata = PDATA_W'(timeout_reg);
            REG_WEIGHT:  prdata = PDATA_W'(weight_reg);
            default:     prdata = '0;
        endcase
    end

    // Scan and age check: one sample per read/check pair
    assign store_full = (count_reg == MAX_CNT);
    assign scan_end   = (k_reg == count_reg);
    assign rd_addr    = ring_pos(oldest_reg, k_reg[IDX_W-1:0]);
    assign age        = now_reg - rd_time_reg;
    assign keep       = (age <= TIME_W'(timeout_reg));

    // Store write port: append a report, or repack a survivor
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ring_pos(oldest_reg, kept_reg[IDX_W-1:0]);
        wr_rtt  = rd_rtt_reg;
        wr_time = rd_time_reg;
        if (state_reg == S_APPEND)
        begin
            wr_en   = 1'b1;
            wr_addr = store_full ? oldest_reg
                                 : ring_pos(oldest_reg, count_reg[IDX_W-1:0]);
            wr_rtt  = rtt_in_reg;
            wr_time = now_reg;
        end
        else if (state_reg == S_CHECK && keep)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_rtt[wr_addr]  <= wr_rtt;
            mem_time[wr_addr] <= wr_time;
        end
        rd_rtt_reg  <= mem_rtt[rd_addr];
        rd_time_reg <= mem_time[rd_addr];
    end

    // Smoothing blend: prev*(10-w) + mean*w, weight clamped at ten
    assign w_eff = (weight_reg > WEIGHT_FULL) ? WEIGHT_FULL : weight_reg;
    assign blend = ({4'b0, avg_reg} * {16'b0, WEIGHT_FULL - w_eff})
                 + ({4'b0, mean_reg} * {16'b0, w_eff});

    // Divide the held blend by ten through the reciprocal
    assign blend_prod = {{BLEND_W{1'b0}}, blend_reg} * {{BLEND_W{1'b0}}, RECIP_TEN};

    // Divider: window mean over the surviving samples
    assign div_start = (state_reg == S_READ && scan_end && kept_reg != '0);
    assign div_num   = sum_reg;
    assign div_den   = kept_reg;

    wrtt_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .done  (div_done)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (req_type == 1'b0) ? S_APPEND : S_READ;
                end
            end
            S_APPEND: state_next = S_READ;
            S_READ:
            begin
                if (scan_end)
                begin
                    state_next = (kept_reg == '0) ? S_DONE : S_DIVM;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: state_next = S_READ;
            S_DIVM:
            begin
                if (div_done)
                begin
                    state_next = avg_valid_reg ? S_MIX : S_DONE;
                end
            end
            S_MIX: state_next = S_DIVA;
            S_DIVA: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state: ring pointers, counts and running average
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            oldest_reg    <= '0;
            count_reg     <= '0;
            avg_reg       <= '0;
            avg_valid_reg <= 1'b0;
            k_reg         <= '0;
            kept_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    k_reg    <= '0;
                    kept_reg <= '0;
                end
                S_APPEND:
                begin
                    if (store_full)
                    begin
                        oldest_reg <= ring_pos(oldest_reg, IDX_W'(1));
                    end
                    else
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                S_READ:
                begin
                    if (scan_end)
                    begin
                        count_reg <= kept_reg;
                        if (kept_reg == '0)
                        begin
                            avg_reg       <= '0;
                            avg_valid_reg <= 1'b0;
                        end
                    end
                end
                S_CHECK:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (keep)
                    begin
                        kept_reg <= kept_reg + 1'b1;
                    end
                end
                S_DIVM:
                begin
                    if (div_done && !avg_valid_reg)
                    begin
                        avg_reg       <= div_quot[RTT_W-1:0];
                        avg_valid_reg <= 1'b1;
                    end
                end
                S_DIVA:
                begin
                    avg_reg <= blend_prod[RECIP_SHIFT +: RTT_W];
                end
                S_MIX, S_DONE:
                begin
                    k_reg <= k_reg;
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    // Item capture and window max/sum
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_reg    <= req_type;
            rtt_in_reg <= rtt_ms;
            now_reg    <= now_ms;
            max_reg    <= '0;
            sum_reg    <= '0;
        end
        else if (state_reg == S_CHECK && keep)
        begin
            sum_reg <= sum_reg + SUM_W'(rd_rtt_reg);
            if (rd_rtt_reg > max_reg)
            begin
                max_reg <= rd_rtt_reg;
            end
        end
        if (state_reg == S_DIVM && div_done)
        begin
            mean_reg <= div_quot[RTT_W-1:0];
        end
        if (state_reg == S_MIX)
        begin
            blend_reg <= blend;
        end
    end

    // Output register: load the result, hold it until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            out_flag_reg <= avg_valid_reg;
            out_max_reg  <= avg_valid_reg ? $signed({1'b0, max_reg}) : '1;
            out_avg_reg  <= avg_valid_reg ? $signed({1'b0, avg_reg}) : '1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign rtt_peak   = out_max_reg;
    assign rtt_smooth = out_avg_reg;
    assign rtt_valid  = out_flag_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("sample count beyond store depth");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg != S_IDLE))
        else $error("sequencer did not start on an accepted item");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVM))
        else $error("divider finished outside the mean step");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_flag_reg) |-> (out_max_reg == '1 && out_avg_reg == '1))
        else $error("empty window result not marked invalid");

    a_req_type_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPEND) |-> (req_reg == 1'b0))
        else $error("append step entered for a tick");

endmodule

/* dv/tb_windowed_rtt_tracker.sv */
// Self-checking testbench for the windowed RTT tracker: directed cases, then randomised phases.
module tb_windowed_rtt_tracker;
    import wrtt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = MAX_SAMPLES_DEF;
    localparam int RUN_LIMIT  = 600_000;
    localparam int END_SETTLE = 120;

    localparam logic signed [RES_W-1:0] RTT_NONE = -17'sd1;

    typedef enum logic {
        REQ_REPORT = 1'b0,
        REQ_TICK   = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic signed [RES_W-1:0] max_rtt;
        logic signed [RES_W-1:0] avg_rtt;
        logic                    valid;
    } window_stats_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic                    req_type;
    logic [RTT_W-1:0]        rtt_ms;
    logic [TIME_W-1:0]       now_ms;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [RES_W-1:0] rtt_peak;
    logic signed [RES_W-1:0] rtt_smooth;
    logic                    rtt_valid;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [PADDR_W-1:0]      paddr;
    logic [PDATA_W-1:0]      pwdata;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;

    // Shadow of the sample window and smoothing state
    logic [RTT_W-1:0]     win_rtt   [DEPTH];
    logic [TIME_W-1:0]    win_stamp [DEPTH];
    int unsigned          win_oldest;
    int unsigned          win_count;
    logic [RTT_W-1:0]     smooth_avg;
    bit                   smooth_valid;
    logic [TIMEOUT_W-1:0] cur_timeout;
    logic [WEIGHT_W-1:0]  cur_weight;

    window_stats_t        pending_stats [$];
    int                   mismatch_count;
    int                   cycle_count;
    bit                   quiet_tail;
    logic [TIME_W-1:0]    clock_ms;

    windowed_rtt_tracker u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .rtt_ms     (rtt_ms),
        .now_ms     (now_ms),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .rtt_peak   (rtt_peak),
        .rtt_smooth (rtt_smooth),
        .rtt_valid  (rtt_valid),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one item to the window shadow and work out its statistics
    function automatic window_stats_t compute_window_stats(input logic kind,
                                                           input logic [RTT_W-1:0] rtt,
                                                           input logic [TIME_W-1:0] now);
        window_stats_t res;
        int unsigned   k, src, dst, kept, sum, mean, w, blend;
        logic [RTT_W-1:0]  peak;
        logic [TIME_W-1:0] age;
        if (kind == REQ_REPORT)
        begin
            if (win_count >= DEPTH)
            begin
                win_oldest = (win_oldest + 1) % DEPTH;
                win_count  = DEPTH - 1;
            end
            dst = (win_oldest + win_count) % DEPTH;
            win_rtt[dst]   = rtt;
            win_stamp[dst] = now;
            win_count++;
        end
        // Drop stale samples, packing survivors from the oldest slot onward
        kept = 0;
        for (k = 0; k < win_count; k++)
        begin
            src = (win_oldest + k) % DEPTH;
            age = now - win_stamp[src];
            if (age <= {16'h0, cur_timeout})
            begin
                dst = (win_oldest + kept) % DEPTH;
                win_rtt[dst]   = win_rtt[src];
                win_stamp[dst] = win_stamp[src];
                kept++;
            end
        end
        win_count = kept;
        if (win_count == 0)
        begin
            smooth_avg   = '0;
            smooth_valid = 1'b0;
            res.max_rtt  = RTT_NONE;
            res.avg_rtt  = RTT_NONE;
            res.valid    = 1'b0;
            return res;
        end
        peak = '0;
        sum  = 0;
        for (k = 0; k < win_count; k++)
        begin
            src = (win_oldest + k) % DEPTH;
            if (win_rtt[src] > peak)
                peak = win_rtt[src];
            sum += win_rtt[src];
        end
        mean = sum / win_count;
        // Blend the window mean into the running average
        w = (cur_weight > WEIGHT_FULL) ? 10 : cur_weight;
        if (!smooth_valid)
            smooth_avg = RTT_W'(mean);
        else
        begin
            blend      = smooth_avg * (10 - w) + mean * w;
            smooth_avg = RTT_W'(blend / 10);
        end
        smooth_valid = 1'b1;
        res.max_rtt  = {1'b0, peak};
        res.avg_rtt  = {1'b0, smooth_avg};
        res.valid    = 1'b1;
        return res;
    endfunction

    // Present one item and hold it until the transfer; valid stays high afterwards
    task automatic send_item(input req_kind_t kind, input logic [RTT_W-1:0] rtt,
                             input logic [TIME_W-1:0] now);
        window_stats_t stats;
        @(negedge clk);
        in_valid = 1'b1;
        req_type = kind;
        rtt_ms   = rtt;
        now_ms   = now;
        do @(posedge clk); while (in_stall);
        stats = compute_window_stats(kind, rtt, now);
        pending_stats.insert(pending_stats.size(), stats);
    endtask

    // Lower valid for a number of cycles
    task automatic idle_input(input int cycles);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Hold off the sender until every expected result has arrived
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_stats.size() != 0) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle; junk above the field width
    task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] field_mask;
        field_mask = (idx == REG_TIMEOUT) ? 32'h0000_FFFF : 32'h0000_000F;
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = (value & field_mask) | ($urandom() & ~field_mask);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == REG_TIMEOUT)
            cur_timeout = value[TIMEOUT_W-1:0];
        else
            cur_weight = value[WEIGHT_W-1:0];
    endtask

    task automatic set_config(input int timeout, input int weight);
        drain_results();
        write_reg(REG_TIMEOUT, timeout);
        write_reg(REG_WEIGHT, weight);
    endtask

    // Empty window at reset, tick ignores its rtt field
    task automatic test_empty_window();
        set_config(TIMEOUT_RST, WEIGHT_RST);
        clock_ms = 32'hFFFF_FF00;
        send_item(REQ_TICK, 16'h0000, clock_ms);
        send_item(REQ_TICK, 16'hFFFF, clock_ms);
    endtask

    // Overfill the store across the time wrap, then age samples out at the boundary
    task automatic test_full_store_and_expiry();
        logic [TIME_W-1:0] first_kept;
        logic [RTT_W-1:0]  rtt;
        first_kept = '0;
        for (int i = 0; i <= DEPTH; i++)
        begin
            clock_ms += 20;
            if (i == 1)
                first_kept = clock_ms;
            case (i % 3)
                0:       rtt = 16'hFFFF;
                1:       rtt = 16'h0000;
                default: rtt = RTT_W'($urandom());
            endcase
            send_item(REQ_REPORT, rtt, clock_ms);
        end
        send_item(REQ_TICK, RTT_W'($urandom()), first_kept + TIMEOUT_RST);
        send_item(REQ_TICK, RTT_W'($urandom()), first_kept + TIMEOUT_RST + 1);
        clock_ms += 5000;
        send_item(REQ_TICK, RTT_W'($urandom()), clock_ms);
    endtask

    // Zero timeout keeps only samples stamped with the current millisecond
    task automatic test_timeout_zero();
        set_config(0, WEIGHT_RST);
        clock_ms += 100;
        send_item(REQ_REPORT, 16'd100, clock_ms);
        send_item(REQ_REPORT, 16'd300, clock_ms);
        send_item(REQ_TICK, 16'd7, clock_ms + 1);
    endtask

    // Weight codes above ten act as full weight
    task automatic test_weight_over_ten();
        set_config(TIMEOUT_RST, 15);
        clock_ms += 10;
        send_item(REQ_REPORT, 16'd1000, clock_ms);
        send_item(REQ_REPORT, 16'd3000, clock_ms + 1);
        set_config(TIMEOUT_RST, 11);
        send_item(REQ_REPORT, 16'd9, clock_ms + 2);
    endtask

    // Mostly well-ordered time with random content; some jumps and stale stamps
    task automatic test_random_phase(input int timeout, input int weight, input int items,
                                     input int idle_pct, input bit pause_mid, input bit tail);
        req_kind_t         kind;
        logic [RTT_W-1:0]  rtt;
        logic [TIME_W-1:0] now;
        int                pick;
        int                step_max;
        set_config(timeout, weight);
        quiet_tail = tail;
        step_max   = (timeout / 6 > 1) ? timeout / 6 : 1;
        for (int i = 0; i < items; i++)
        begin
            kind = ($urandom_range(0, 99) < 65) ? REQ_REPORT : REQ_TICK;
            case ($urandom_range(0, 9))
                0:       rtt = 16'h0000;
                1:       rtt = 16'hFFFF;
                2:       rtt = RTT_W'($urandom_range(0, 255));
                default: rtt = RTT_W'($urandom());
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                clock_ms += $urandom_range(0, step_max);
                now = clock_ms;
            end
            else if (pick < 88)
            begin
                clock_ms += timeout + $urandom_range(0, 2);
                now = clock_ms;
            end
            else if (pick < 94)
            begin
                clock_ms = $urandom();
                now = clock_ms;
            end
            else
                now = clock_ms - $urandom_range(1, 50);
            send_item(kind, rtt, now);
            if (pause_mid && i == items / 2)
                drain_results();
            else if (!tail && $urandom_range(0, 99) < idle_pct)
                idle_input($urandom_range(1, 12));
        end
    endtask

    // Receiver stalls in bursts, with calm stretches between
    initial
    begin : out_stall_gen
        int span;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet_tail || $urandom_range(0, 3) != 0)
            begin
                out_stall = 1'b0;
                span = $urandom_range(1, 40);
            end
            else
            begin
                out_stall = 1'b1;
                span = $urandom_range(1, 12);
            end
            repeat (span - 1) @(negedge clk);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        window_stats_t exp_stats;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_stats.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result peak %0d smooth %0d valid %0b", $time,
                         rtt_peak, rtt_smooth, rtt_valid);
            end
            else
            begin
                exp_stats = pending_stats.pop_front();
                if (rtt_peak !== exp_stats.max_rtt)
                begin
                    mismatch_count++;
                    $display("%0t: rtt_peak expected %0d got %0d", $time,
                             exp_stats.max_rtt, rtt_peak);
                end
                if (rtt_smooth !== exp_stats.avg_rtt)
                begin
                    mismatch_count++;
                    $display("%0t: rtt_smooth expected %0d got %0d", $time,
                             exp_stats.avg_rtt, rtt_smooth);
                end
                if (rtt_valid !== exp_stats.valid)
                begin
                    mismatch_count++;
                    $display("%0t: rtt_valid expected %0b got %0b", $time,
                             exp_stats.valid, rtt_valid);
                end
            end
        end
    end

    // Abandon a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        req_type       = REQ_REPORT;
        rtt_ms         = '0;
        now_ms         = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        quiet_tail     = 1'b0;
        clock_ms       = '0;
        win_oldest     = 0;
        win_count      = 0;
        smooth_avg     = '0;
        smooth_valid   = 1'b0;
        cur_timeout    = TIMEOUT_RST;
        cur_weight     = WEIGHT_RST;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_empty_window();
        test_full_store_and_expiry();
        test_timeout_zero();
        test_weight_over_ten();
        test_random_phase(TIMEOUT_RST, WEIGHT_RST, 150, 30, 1'b1, 1'b0);
        test_random_phase(65535, 10, 130, 50, 1'b0, 1'b0);
        test_random_phase(1, 0, 100, 0, 1'b0, 1'b0);
        test_random_phase(0, 15, 90, 30, 1'b0, 1'b0);
        test_random_phase($urandom_range(1, 65535), $urandom_range(0, 15), 130, 20,
                          1'b0, 1'b0);
        test_random_phase(20000, 11, 120, 40, 1'b0, 1'b0);
        test_random_phase($urandom_range(2, 5000), 7, 130, 0, 1'b0, 1'b1);

        drain_results();
        repeat (END_SETTLE) @(posedge clk);
        if (mismatch_count == 0 && pending_stats.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/wrtt_pkg.sv
rtl/core/wrtt_div.sv
rtl/core/windowed_rtt_tracker.sv
dv/tb_windowed_rtt_tracker.sv
